FILE: design/impq_pkg.sv
// Shared types and constants for the indexed max priority queue.
// No dependencies; used by impq_cell and indexed_max_priority_queue.
`timescale 1ns / 1ps
`default_nettype none

package impq_pkg;

  // Fixed field widths of the transaction payloads
  localparam int KEY_BITS    = 6;
  localparam int AMOUNT_BITS = 10;
  localparam int MODE_BITS   = 2;
  localparam int STATUS_BITS = 2;

  // Defaults for the top-level parameters
  localparam int ENTRIES_DEF    = 64;
  localparam int LEVEL_BITS_DEF = 16;
  localparam int STAMP_BITS_DEF = 32;

  // Operation codes on the mode field
  localparam logic [MODE_BITS-1:0] MODE_INSERT   = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_INCREASE = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_REMOVE   = 2'd2;
  localparam logic [MODE_BITS-1:0] MODE_QUERY    = 2'd3;

  // Result status codes
  localparam logic [STATUS_BITS-1:0] STATUS_DONE    = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_PRESENT = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_ABSENT  = 2'd2;

  // Command broadcast to every cell of the chain for one update cycle
  typedef struct packed {
    logic ins;  // place the new entry in rank order
    logic inc;  // move the raised entry forward to its new rank
    logic del;  // close the gap left by the removed entry
  } op_t;

endpackage

`default_nettype wire

FILE: design/indexed_max_priority_queue.sv
// Keyed max priority queue built as a sorted chain of entry cells.
// Depends on impq_pkg and impq_cell.
//
// Usage:
//   Command channel (cmd_valid / cmd_stall) carries mode, key and amount:
//   insert, increase level, remove or query. Response channel
//   (rsp_valid / rsp_stall) returns exactly one transaction per command:
//   status, is_empty and top_key (0 when the queue is empty).
//   The cells are kept sorted by rank, so the top entry always sits in
//   the first cell. Key lookup, the saturating level add and the stamp
//   are resolved in the acceptance cycle; the next cycle moves the whole
//   chain by at most one slot per cell (increase is a single move window).
//   An accepted command is registered with its lookup results, the chain
//   is updated in S_APPLY and the response is loaded from S_DONE; no new
//   command is taken before the previous one reaches S_DONE.
//   A new command is taken in the same cycle the previous response is
//   loaded into the output register.
//   When rsp_stall is held, the response stays in the output register and
//   cmd_stall rises once the next result is ready to be loaded.
//   Reset (rst, synchronous) empties every cell, clears the arrival
//   stamp counter and drops any pending response; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module indexed_max_priority_queue #(
  parameter int ENTRIES    = impq_pkg::ENTRIES_DEF,
  parameter int LEVEL_BITS = impq_pkg::LEVEL_BITS_DEF,
  parameter int STAMP_BITS = impq_pkg::STAMP_BITS_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cmd_valid,
  output logic                             cmd_stall,
  input  wire [impq_pkg::MODE_BITS-1:0]    mode,
  input  wire [impq_pkg::KEY_BITS-1:0]     key,
  input  wire [impq_pkg::AMOUNT_BITS-1:0]  amount,
  output logic                             rsp_valid,
  input  wire                              rsp_stall,
  output logic [impq_pkg::STATUS_BITS-1:0] status,
  output logic                             is_empty,
  output logic [impq_pkg::KEY_BITS-1:0]    top_key
);

  localparam bit ALL_KEYS = ENTRIES >= (1 << impq_pkg::KEY_BITS);
  localparam int SUM_W = ((LEVEL_BITS > impq_pkg::AMOUNT_BITS) ?
                          LEVEL_BITS : impq_pkg::AMOUNT_BITS) + 1;
  localparam logic [SUM_W-1:0] LEVEL_MAX =
    {{(SUM_W - LEVEL_BITS){1'b0}}, {LEVEL_BITS{1'b1}}};

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_APPLY = 3'b010,
    S_DONE  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // Cell chain wiring
  logic [ENTRIES-1:0]            c_valid;
  logic [LEVEL_BITS-1:0]         c_level [ENTRIES];
  logic [STAMP_BITS-1:0]         c_stamp [ENTRIES];
  logic [impq_pkg::KEY_BITS-1:0] c_key   [ENTRIES];
  logic [ENTRIES-1:0]            c_shift;
  logic [ENTRIES-1:0]            c_match;
  impq_pkg::op_t                 cell_op;

  // Registered command after lookup
  impq_pkg::op_t                    op;
  logic [impq_pkg::STATUS_BITS-1:0] st;
  logic [LEVEL_BITS-1:0]            n_level;
  logic [STAMP_BITS-1:0]            n_stamp;
  logic [impq_pkg::KEY_BITS-1:0]    n_key;
  logic [LEVEL_BITS-1:0]            r_level;
  logic [STAMP_BITS-1:0]            r_stamp;
  logic [STAMP_BITS-1:0]            arrival;

  // Lookup results on the command ports
  logic                             accept;
  logic                             rsp_free;
  logic                             in_range;
  logic                             present;
  logic [LEVEL_BITS-1:0]            sel_level;
  logic [STAMP_BITS-1:0]            sel_stamp;
  logic [LEVEL_BITS-1:0]            lvl_base;
  logic [SUM_W-1:0]                 lvl_sum;
  logic [LEVEL_BITS-1:0]            lvl_sat;
  impq_pkg::op_t                    op_next;
  logic [impq_pkg::STATUS_BITS-1:0] st_next;
  logic [ENTRIES-1:0]               valid_inc;

  // Handshake
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign cmd_stall = !((state == S_IDLE) || ((state == S_DONE) && rsp_free));
  assign accept    = cmd_valid && !cmd_stall;

  // Sequencer
  always_comb begin
    unique case (state)
      S_IDLE: begin
        state_next = accept ? S_APPLY : S_IDLE;
      end
      S_APPLY: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        priority if (accept) begin
          state_next = S_APPLY;
        end else if (rsp_free) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_DONE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Select the matching entry (at most one cell matches)
  always_comb begin
    sel_level = '0;
    sel_stamp = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (c_match[i]) begin
        sel_level = sel_level | c_level[i];
        sel_stamp = sel_stamp | c_stamp[i];
      end
    end
  end

  assign in_range = ALL_KEYS || (int'(key) < ENTRIES);
  assign present  = in_range && (|c_match);

  // Saturating level: initial amount on insert, old level plus amount on increase
  assign lvl_base = (mode == impq_pkg::MODE_INCREASE) ? sel_level : '0;
  assign lvl_sum  = SUM_W'(lvl_base) + SUM_W'(amount);
  assign lvl_sat  = (lvl_sum > LEVEL_MAX) ? '1 : lvl_sum[LEVEL_BITS-1:0];

  // Decode the command into a chain operation and a status
  always_comb begin
    op_next = '0;
    st_next = impq_pkg::STATUS_DONE;
    unique case (mode)
      impq_pkg::MODE_INSERT: begin
        priority if (!in_range) begin
          st_next = impq_pkg::STATUS_ABSENT;
        end else if (present) begin
          st_next = impq_pkg::STATUS_PRESENT;
        end else begin
          op_next.ins = 1'b1;
        end
      end
      impq_pkg::MODE_INCREASE: begin
        if (present) begin
          op_next.inc = 1'b1;
        end else begin
          st_next = impq_pkg::STATUS_ABSENT;
        end
      end
      impq_pkg::MODE_REMOVE: begin
        if (present) begin
          op_next.del = 1'b1;
        end else begin
          st_next = impq_pkg::STATUS_ABSENT;
        end
      end
      impq_pkg::MODE_QUERY: begin
        st_next = impq_pkg::STATUS_DONE;
      end
      default: begin
        st_next = impq_pkg::STATUS_DONE;
      end
    endcase
  end

  // Arrival stamp counter, advanced by each accepted insert
  always_ff @(posedge clk) begin
    if (rst) begin
      arrival <= '0;
    end else if (accept && op_next.ins) begin
      arrival <= arrival + STAMP_BITS'(1);
    end
  end

  // Command registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op      <= op_next;
      st      <= st_next;
      n_level <= lvl_sat;
      n_stamp <= op_next.ins ? arrival : sel_stamp;
      n_key   <= key;
      r_level <= sel_level;
      r_stamp <= sel_stamp;
    end
  end

  assign cell_op = (state == S_APPLY) ? op : '0;

  // Sorted cell chain, top entry in cell 0
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic                          p_valid;
    logic [LEVEL_BITS-1:0]         p_level;
    logic [STAMP_BITS-1:0]         p_stamp;
    logic [impq_pkg::KEY_BITS-1:0] p_key;
    logic                          p_shift;
    logic                          x_valid;
    logic [LEVEL_BITS-1:0]         x_level;
    logic [STAMP_BITS-1:0]         x_stamp;
    logic [impq_pkg::KEY_BITS-1:0] x_key;

    if (i == 0) begin : g_head
      assign p_valid = 1'b0;
      assign p_level = '0;
      assign p_stamp = '0;
      assign p_key   = '0;
      assign p_shift = 1'b0;
    end else begin : g_link_prev
      assign p_valid = c_valid[i-1];
      assign p_level = c_level[i-1];
      assign p_stamp = c_stamp[i-1];
      assign p_key   = c_key[i-1];
      assign p_shift = c_shift[i-1];
    end

    if (i == ENTRIES - 1) begin : g_tail
      assign x_valid = 1'b0;
      assign x_level = '0;
      assign x_stamp = '0;
      assign x_key   = '0;
    end else begin : g_link_next
      assign x_valid = c_valid[i+1];
      assign x_level = c_level[i+1];
      assign x_stamp = c_stamp[i+1];
      assign x_key   = c_key[i+1];
    end

    impq_cell #(
      .LEVEL_BITS (LEVEL_BITS),
      .STAMP_BITS (STAMP_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .op         (cell_op),
      .lookup_key (key),
      .n_level    (n_level),
      .n_stamp    (n_stamp),
      .n_key      (n_key),
      .r_level    (r_level),
      .r_stamp    (r_stamp),
      .r_key      (n_key),
      .prev_valid (p_valid),
      .prev_level (p_level),
      .prev_stamp (p_stamp),
      .prev_key   (p_key),
      .prev_shift (p_shift),
      .next_valid (x_valid),
      .next_level (x_level),
      .next_stamp (x_stamp),
      .next_key   (x_key),
      .e_valid    (c_valid[i]),
      .e_level    (c_level[i]),
      .e_stamp    (c_stamp[i]),
      .e_key      (c_key[i]),
      .shift      (c_shift[i]),
      .match      (c_match[i])
    );
  end

  // Response register, loaded from the head cell after the update
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((state == S_DONE) && rsp_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && rsp_free) begin
      status   <= st;
      is_empty <= !c_valid[0];
      top_key  <= c_valid[0] ? c_key[0] : '0;
    end
  end

  // Checks
  assign valid_inc = c_valid + ENTRIES'(1);

  a_packed: assert property (@(posedge clk) disable iff (rst)
    (valid_inc & c_valid) == '0)
    else $error("valid cells are not packed toward the head");

  a_unique_key: assert property (@(posedge clk) disable iff (rst)
    $onehot0(c_match))
    else $error("key held in more than one cell");

  a_ins_count: assert property (@(posedge clk) disable iff (rst)
    cell_op.ins |=> $countones(c_valid) == $past($countones(c_valid)) + 1)
    else $error("insert did not add exactly one entry");

  a_del_count: assert property (@(posedge clk) disable iff (rst)
    cell_op.del |=> $countones(c_valid) == $past($countones(c_valid)) - 1)
    else $error("remove did not drop exactly one entry");

  a_inc_count: assert property (@(posedge clk) disable iff (rst)
    cell_op.inc |=> $countones(c_valid) == $past($countones(c_valid)))
    else $error("increase changed the number of entries");

endmodule

`default_nettype wire

FILE: design/impq_cell.sv
// One slot of the sorted entry chain: holds an entry and ranks it against
// the broadcast new and reference entries. Depends on impq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module impq_cell #(
  parameter int LEVEL_BITS = impq_pkg::LEVEL_BITS_DEF,
  parameter int STAMP_BITS = impq_pkg::STAMP_BITS_DEF
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire impq_pkg::op_t           op,
  input  wire [impq_pkg::KEY_BITS-1:0] lookup_key,
  // entry being placed (insert or raised entry)
  input  wire [LEVEL_BITS-1:0]         n_level,
  input  wire [STAMP_BITS-1:0]         n_stamp,
  input  wire [impq_pkg::KEY_BITS-1:0] n_key,
  // entry as it stood before the operation (increase or remove)
  input  wire [LEVEL_BITS-1:0]         r_level,
  input  wire [STAMP_BITS-1:0]         r_stamp,
  input  wire [impq_pkg::KEY_BITS-1:0] r_key,
  // neighbor toward the top
  input  wire                          prev_valid,
  input  wire [LEVEL_BITS-1:0]         prev_level,
  input  wire [STAMP_BITS-1:0]         prev_stamp,
  input  wire [impq_pkg::KEY_BITS-1:0] prev_key,
  input  wire                          prev_shift,
  // neighbor toward the tail
  input  wire                          next_valid,
  input  wire [LEVEL_BITS-1:0]         next_level,
  input  wire [STAMP_BITS-1:0]         next_stamp,
  input  wire [impq_pkg::KEY_BITS-1:0] next_key,
  // own entry
  output logic                         e_valid,
  output logic [LEVEL_BITS-1:0]        e_level,
  output logic [STAMP_BITS-1:0]        e_stamp,
  output logic [impq_pkg::KEY_BITS-1:0] e_key,
  output logic                         shift,
  output logic                         match
);

  logic                          beats_n;
  logic                          beats_r;
  logic                          r_beats;
  logic                          take_next;
  logic                          e_valid_next;
  logic [LEVEL_BITS-1:0]         e_level_next;
  logic [STAMP_BITS-1:0]         e_stamp_next;
  logic [impq_pkg::KEY_BITS-1:0] e_key_next;

  // Rank order: higher level, then smaller stamp, then smaller key
  assign beats_n = e_valid && ((e_level > n_level) ||
                   ((e_level == n_level) && ((e_stamp < n_stamp) ||
                   ((e_stamp == n_stamp) && (e_key < n_key)))));
  assign beats_r = e_valid && ((e_level > r_level) ||
                   ((e_level == r_level) && ((e_stamp < r_stamp) ||
                   ((e_stamp == r_stamp) && (e_key < r_key)))));
  assign r_beats = e_valid && ((r_level > e_level) ||
                   ((r_level == e_level) && ((r_stamp < e_stamp) ||
                   ((r_stamp == e_stamp) && (r_key < e_key)))));

  assign match = e_valid && (e_key == lookup_key);

  // Shift toward the tail inside the window opened by the placed entry;
  // on increase the window ends at the entry's old slot.
  always_comb begin
    priority if (op.ins) begin
      shift = !beats_n;
    end else if (op.inc) begin
      shift = e_valid && !beats_n && !r_beats;
    end else begin
      shift = 1'b0;
    end
  end

  // At or behind the removed entry: pull from the tail side
  assign take_next = op.del && !beats_r;

  // Next entry selection
  always_comb begin
    priority if (shift && prev_shift) begin
      e_valid_next = prev_valid;
      e_level_next = prev_level;
      e_stamp_next = prev_stamp;
      e_key_next   = prev_key;
    end else if (shift) begin
      e_valid_next = 1'b1;
      e_level_next = n_level;
      e_stamp_next = n_stamp;
      e_key_next   = n_key;
    end else if (take_next) begin
      e_valid_next = next_valid;
      e_level_next = next_level;
      e_stamp_next = next_stamp;
      e_key_next   = next_key;
    end else begin
      e_valid_next = e_valid;
      e_level_next = e_level;
      e_stamp_next = e_stamp;
      e_key_next   = e_key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else begin
      e_valid <= e_valid_next;
    end
  end

  // Payload carries no reset; it is only read while valid
  always_ff @(posedge clk) begin
    e_level <= e_level_next;
    e_stamp <= e_stamp_next;
    e_key   <= e_key_next;
  end

endmodule

`default_nettype wire

FILE: dv/indexed_max_priority_queue_tb.sv
// Self-checking testbench for indexed_max_priority_queue: directed, saturation,
// fill/drain, backpressure and random command mixes checked against a local predictor.
// Depends on impq_pkg and the indexed_max_priority_queue RTL.
`timescale 1ns / 1ps

module indexed_max_priority_queue_tb;

  localparam int LEVEL_BITS    = impq_pkg::LEVEL_BITS_DEF;
  localparam int STAMP_BITS    = impq_pkg::STAMP_BITS_DEF;
  localparam int KEY_BITS      = impq_pkg::KEY_BITS;
  localparam int AMOUNT_BITS   = impq_pkg::AMOUNT_BITS;
  localparam int MODE_BITS     = impq_pkg::MODE_BITS;
  localparam int STATUS_BITS   = impq_pkg::STATUS_BITS;
  localparam int SLOTS         = 1 << KEY_BITS;
  localparam int RESET_CYCLES  = 7;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int IDLE_LIMIT    = 2000;
  localparam int RANDOM_PHASE  = 120;
  localparam int BP_COMMANDS   = 16;
  localparam int SAT_BUMPS     = 65;

  localparam logic [LEVEL_BITS-1:0]  LEVEL_MAX  = '1;
  localparam logic [AMOUNT_BITS-1:0] AMOUNT_MAX = '1;

  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic                   is_empty;
    logic [KEY_BITS-1:0]    top_key;
  } queue_reply_t;

  // DUT connections, all inputs known from time zero
  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cmd_valid = 1'b0;
  logic                   cmd_stall;
  logic [MODE_BITS-1:0]   mode = impq_pkg::MODE_QUERY;
  logic [KEY_BITS-1:0]    key = '0;
  logic [AMOUNT_BITS-1:0] amount = '0;
  logic                   rsp_valid;
  logic                   rsp_stall = 1'b0;
  logic [STATUS_BITS-1:0] status;
  logic                   is_empty;
  logic [KEY_BITS-1:0]    top_key;

  // Predicted queue contents
  bit                     held [SLOTS];
  logic [LEVEL_BITS-1:0]  level_of [SLOTS];
  logic [STAMP_BITS-1:0]  stamp_of [SLOTS];
  logic [STAMP_BITS-1:0]  arrivals;
  int                     occupancy;

  queue_reply_t expected_replies [$];

  // Run bookkeeping
  int errors;
  int replies_checked;
  int cmd_count [4];
  int dup_inserts;
  int absent_ops;
  int sat_hits;
  int input_stall_cycles;
  int idle_cycles;

  // Sender pacing and receiver stall control
  bit gaps_on;
  int burst_left;
  int stall_style;
  bit hold_req;
  int hold_left;
  int stall_phase;

  indexed_max_priority_queue dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .mode      (mode),
    .key       (key),
    .amount    (amount),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .status    (status),
    .is_empty  (is_empty),
    .top_key   (top_key)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Apply one command to the predicted queue and return the reply it owes
  function automatic queue_reply_t apply_queue_op(logic [MODE_BITS-1:0] op,
                                                  logic [KEY_BITS-1:0] k,
                                                  logic [AMOUNT_BITS-1:0] amt);
    queue_reply_t          r;
    logic [LEVEL_BITS:0]   sum;
    bit                    found;
    logic [LEVEL_BITS-1:0] best_lvl;
    logic [STAMP_BITS-1:0] best_stamp;
    r.status  = impq_pkg::STATUS_DONE;
    r.top_key = '0;
    case (op)
      impq_pkg::MODE_INSERT: begin
        if (held[k]) begin
          r.status = impq_pkg::STATUS_PRESENT;
        end else begin
          held[k]     = 1'b1;
          level_of[k] = LEVEL_BITS'(amt);
          stamp_of[k] = arrivals;
          arrivals    = arrivals + 1'b1;
          occupancy++;
        end
      end
      impq_pkg::MODE_INCREASE: begin
        if (!held[k]) begin
          r.status = impq_pkg::STATUS_ABSENT;
        end else begin
          sum = level_of[k] + amt;
          if (sum > LEVEL_MAX) begin
            level_of[k] = LEVEL_MAX;
            sat_hits++;
          end else begin
            level_of[k] = sum[LEVEL_BITS-1:0];
          end
        end
      end
      impq_pkg::MODE_REMOVE: begin
        if (!held[k]) begin
          r.status = impq_pkg::STATUS_ABSENT;
        end else begin
          held[k] = 1'b0;
          occupancy--;
        end
      end
      default: ;
    endcase
    // Highest level wins; on a tie the smaller stamp (earlier insert) wins
    found = 1'b0;
    best_lvl = '0;
    best_stamp = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (held[i] && (!found || level_of[i] > best_lvl ||
                      (level_of[i] == best_lvl && stamp_of[i] < best_stamp))) begin
        found      = 1'b1;
        r.top_key  = KEY_BITS'(i);
        best_lvl   = level_of[i];
        best_stamp = stamp_of[i];
      end
    end
    r.is_empty = (occupancy == 0);
    if (r.status == impq_pkg::STATUS_PRESENT) dup_inserts++;
    if (r.status == impq_pkg::STATUS_ABSENT) absent_ops++;
    return r;
  endfunction

  // Random key that is (or is not) currently held; any key if none qualifies
  function automatic logic [KEY_BITS-1:0] pick_key(bit want_held);
    logic [KEY_BITS-1:0] k;
    for (int t = 0; t < 4 * SLOTS; t++) begin
      k = KEY_BITS'($urandom_range(0, SLOTS - 1));
      if (held[k] == want_held) return k;
    end
    return KEY_BITS'($urandom_range(0, SLOTS - 1));
  endfunction

  // Amounts lean toward small values and the extremes so ties and overflow occur
  function automatic logic [AMOUNT_BITS-1:0] pick_amount();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 20) return AMOUNT_BITS'($urandom_range(0, 3));
    if (roll < 30) return '0;
    if (roll < 40) return AMOUNT_MAX;
    return AMOUNT_BITS'($urandom_range(0, (1 << AMOUNT_BITS) - 1));
  endfunction

  // Offer one command, wait for the handshake, record the expected reply,
  // then idle for a random gap at the end of a burst
  task automatic send_command(input logic [MODE_BITS-1:0] op,
                              input logic [KEY_BITS-1:0] k,
                              input logic [AMOUNT_BITS-1:0] amt);
    int gap;
    cmd_valid <= 1'b1;
    mode      <= op;
    key       <= k;
    amount    <= amt;
    @(posedge clk);
    while (cmd_stall !== 1'b0) @(posedge clk);
    expected_replies.push_back(apply_queue_op(op, k, amt));
    cmd_count[op]++;
    if (gaps_on) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 15);
        gap = $urandom_range(1, 8);
        cmd_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stop offering and let every outstanding reply come back
  task automatic drain_pipeline();
    cmd_valid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Empty queue, absent keys, duplicates, ties and emptying out
  task automatic test_directed();
    send_command(impq_pkg::MODE_QUERY, 6'd0, '0);
    send_command(impq_pkg::MODE_INCREASE, 6'd5, 10'd1);
    send_command(impq_pkg::MODE_REMOVE, 6'd63, '0);
    send_command(impq_pkg::MODE_INSERT, 6'd0, '0);
    send_command(impq_pkg::MODE_INSERT, 6'd63, '0);
    send_command(impq_pkg::MODE_INSERT, 6'd0, 10'd9);
    send_command(impq_pkg::MODE_INCREASE, 6'd63, 10'd1);
    send_command(impq_pkg::MODE_INSERT, 6'd10, AMOUNT_MAX);
    send_command(impq_pkg::MODE_INSERT, 6'd20, AMOUNT_MAX);
    send_command(impq_pkg::MODE_REMOVE, 6'd10, '0);
    send_command(impq_pkg::MODE_QUERY, 6'd42, AMOUNT_MAX);
    send_command(impq_pkg::MODE_INCREASE, 6'd0, AMOUNT_MAX);
    send_command(impq_pkg::MODE_INCREASE, 6'd20, '0);
    send_command(impq_pkg::MODE_REMOVE, 6'd0, '0);
    send_command(impq_pkg::MODE_REMOVE, 6'd63, '0);
    send_command(impq_pkg::MODE_REMOVE, 6'd20, '0);
    send_command(impq_pkg::MODE_REMOVE, 6'd20, '0);
    send_command(impq_pkg::MODE_QUERY, 6'd63, '0);
    drain_pipeline();
  endtask

  // Two keys pushed into level saturation; the earlier insert keeps the top
  task automatic test_saturation();
    send_command(impq_pkg::MODE_INSERT, 6'd7, AMOUNT_MAX);
    repeat (SAT_BUMPS) send_command(impq_pkg::MODE_INCREASE, 6'd7, AMOUNT_MAX);
    send_command(impq_pkg::MODE_INSERT, 6'd8, AMOUNT_MAX);
    repeat (SAT_BUMPS) send_command(impq_pkg::MODE_INCREASE, 6'd8, AMOUNT_MAX);
    send_command(impq_pkg::MODE_INCREASE, 6'd7, '0);
    send_command(impq_pkg::MODE_REMOVE, 6'd7, '0);
    send_command(impq_pkg::MODE_REMOVE, 6'd8, '0);
    drain_pipeline();
  endtask

  // Every slot filled in random order, shuffled raises, then emptied
  task automatic test_fill_and_drain();
    logic [KEY_BITS-1:0] order [SLOTS];
    logic [KEY_BITS-1:0] tmp;
    int j;
    for (int i = 0; i < SLOTS; i++) order[i] = KEY_BITS'(i);
    for (int i = SLOTS - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < SLOTS; i++)
      send_command(impq_pkg::MODE_INSERT, order[i], pick_amount());
    repeat (40) send_command(impq_pkg::MODE_INCREASE, pick_key(1'b1), pick_amount());
    send_command(impq_pkg::MODE_INSERT, order[0], pick_amount());
    for (int i = SLOTS - 1; i >= 0; i--) send_command(impq_pkg::MODE_REMOVE, order[i], '0);
    drain_pipeline();
  endtask

  // Receiver holds off for a long stretch while commands keep coming back to back
  task automatic test_backpressure();
    gaps_on  = 1'b0;
    hold_req = 1'b1;
    for (int i = 0; i < BP_COMMANDS; i++) begin
      if (i % 4 == 3) send_command(impq_pkg::MODE_QUERY, pick_key(1'b0), pick_amount());
      else send_command(impq_pkg::MODE_INSERT, pick_key(1'b0), pick_amount());
    end
    gaps_on = 1'b1;
    drain_pipeline();
  endtask

  // Mostly meaningful commands against the live contents, some noise
  task automatic test_random_mix();
    int roll;
    int ins_weight;
    for (int phase = 0; phase < 4; phase++) begin
      stall_style = phase;
      gaps_on     = (phase != 0);
      for (int n = 0; n < RANDOM_PHASE; n++) begin
        ins_weight = (occupancy < 16) ? 45 : (occupancy > 56) ? 10 : 30;
        roll = $urandom_range(0, 99);
        if (roll < ins_weight)
          send_command(impq_pkg::MODE_INSERT, pick_key(1'b0), pick_amount());
        else if (roll < ins_weight + 25)
          send_command(impq_pkg::MODE_INCREASE, pick_key(1'b1), pick_amount());
        else if (roll < ins_weight + 45)
          send_command(impq_pkg::MODE_REMOVE, pick_key(1'b1), pick_amount());
        else if (roll < ins_weight + 55)
          send_command(impq_pkg::MODE_QUERY, KEY_BITS'($urandom), pick_amount());
        else
          send_command(MODE_BITS'($urandom), KEY_BITS'($urandom), AMOUNT_BITS'($urandom));
      end
      drain_pipeline();
    end
  endtask

  // Receiver stall: a long hold on request, otherwise one of several patterns
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      rsp_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      rsp_stall <= 1'b1;
    end else begin
      case (stall_style)
        0: rsp_stall <= 1'b0;
        1: rsp_stall <= ($urandom_range(0, 99) < 25);
        2: rsp_stall <= ($urandom_range(0, 99) < 70);
        default: rsp_stall <= ((stall_phase % 7) < 3);
      endcase
    end
  end

  // Compare each accepted response with the oldest expectation
  always @(posedge clk) begin
    queue_reply_t exp;
    if (!rst && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
      if (expected_replies.size() == 0) begin
        $error("unexpected response: status %0d is_empty %0d top_key %0d",
               status, is_empty, top_key);
        errors++;
      end else begin
        exp = expected_replies.pop_front();
        replies_checked++;
        if (status !== exp.status) begin
          $error("status: expected %0d, got %0d", exp.status, status);
          errors++;
        end
        if (is_empty !== exp.is_empty) begin
          $error("is_empty: expected %0d, got %0d", exp.is_empty, is_empty);
          errors++;
        end
        if (top_key !== exp.top_key) begin
          $error("top_key: expected %0d, got %0d", exp.top_key, top_key);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (cmd_valid && cmd_stall === 1'b1) input_stall_cycles++;
    if ((cmd_valid && cmd_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
      idle_cycles = 0;
    else
      idle_cycles = idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles, %0d responses outstanding",
               idle_cycles, expected_replies.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    arrivals    = '0;
    occupancy   = 0;
    gaps_on     = 1'b1;
    stall_style = 1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_saturation();
    test_fill_and_drain();
    test_backpressure();
    test_random_mix();

    if (expected_replies.size() != 0) begin
      $error("%0d expected responses never arrived", expected_replies.size());
      errors++;
    end
    $display("run: %0d inserts, %0d increases, %0d removes, %0d queries; %0d checked",
             cmd_count[impq_pkg::MODE_INSERT], cmd_count[impq_pkg::MODE_INCREASE],
             cmd_count[impq_pkg::MODE_REMOVE], cmd_count[impq_pkg::MODE_QUERY],
             replies_checked);
    $display("     %0d duplicate inserts, %0d absent-key ops, %0d saturations, %0d input stalls",
             dup_inserts, absent_ops, sat_hits, input_stall_cycles);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
